/* src/assert_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cdnc_pkg.sv */
// Types, constants and tables of the calendar and day count converter.
`timescale 1ns / 1ps

package cdnc_pkg;

    localparam logic OP_TO_DAYS = 1'b0;
    localparam logic OP_TO_CAL  = 1'b1;

    localparam int unsigned YEAR_MIN      = 1900;
    localparam int unsigned SEC_PER_DAY   = 86400;
    localparam int unsigned EPOCH_SHIFT   = 693902;
    localparam int unsigned MAX_DAY       = 2958463;
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned DAYS_PER_QUAD = 1461;
    localparam int unsigned MONTH_SPAN    = 153;

    // Reciprocals for exact division by a constant: q = (x * RCP) >> K.
    // Each K is chosen so that the largest dividend times the divisor stays below 2**K.
    localparam int unsigned K_DIV100 = 21;
    localparam int unsigned RCP_DIV100 = ((1 << K_DIV100) + 99) / 100;
    localparam int unsigned K_DIV_ERA = 41;
    localparam longint unsigned RCP_DIV_ERA =
        ((64'd1 << K_DIV_ERA) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA);
    localparam int unsigned K_DIV_QUAD = 28;
    localparam int unsigned RCP_DIV_QUAD =
        ((1 << K_DIV_QUAD) + DAYS_PER_QUAD - 1) / DAYS_PER_QUAD;
    localparam int unsigned K_DIV_MON = 19;
    localparam int unsigned RCP_DIV_MON = ((1 << K_DIV_MON) + MONTH_SPAN - 1) / MONTH_SPAN;
    localparam int unsigned K_DIV60 = 23;
    localparam int unsigned RCP_DIV60 = ((1 << K_DIV60) + 59) / 60;
    localparam int unsigned K_DIV60H = 17;
    localparam int unsigned RCP_DIV60H = ((1 << K_DIV60H) + 59) / 60;
    localparam int unsigned K_DIV5 = 10;
    localparam int unsigned RCP_DIV5 = ((1 << K_DIV5) + 4) / 5;

    typedef struct packed {
        logic        opcode;
        logic [13:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
        logic [21:0] day_index;
        logic [16:0] second_of_day;
    } t_in_item;

    typedef struct packed {
        logic [21:0] res_day_index;
        logic [16:0] res_second_of_day;
        logic [13:0] res_year;
        logic [3:0]  res_month;
        logic [4:0]  res_day;
        logic [4:0]  res_hour;
        logic [5:0]  res_minute;
        logic [5:0]  res_second;
    } t_out_item;

    // Days from March 1 to the first day of a March-based month, (153 * mo + 2) / 5.
    function automatic logic [8:0] days_before_month(input logic [3:0] mo);
        case (mo)
            4'd0:    days_before_month = 9'd0;
            4'd1:    days_before_month = 9'd31;
            4'd2:    days_before_month = 9'd61;
            4'd3:    days_before_month = 9'd92;
            4'd4:    days_before_month = 9'd122;
            4'd5:    days_before_month = 9'd153;
            4'd6:    days_before_month = 9'd184;
            4'd7:    days_before_month = 9'd214;
            4'd8:    days_before_month = 9'd245;
            4'd9:    days_before_month = 9'd275;
            4'd10:   days_before_month = 9'd306;
            4'd11:   days_before_month = 9'd337;
            4'd12:   days_before_month = 9'd367;
            4'd13:   days_before_month = 9'd398;
            default: days_before_month = 9'd0;
        endcase
    endfunction

endpackage

/* src/cdnc_chan_if.sv */
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps

interface cdnc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/calendar_day_number_converter.sv */
// Calendar fields to day count since 1900-01-01 and back, nine-stage pipeline.
//
// Input channel i_in carries a t_in_item; opcode OP_TO_DAYS turns year, month,
// day and clock time into a day count and second of day, OP_TO_CAL turns a day
// count and second of day into calendar and clock fields. Fields of the other
// direction are zero in the result. Output channel o_out carries a t_out_item.
// Both channels use valid/ready; an item moves when both are high.
// A result passes through the nine pipeline stages and then the output register
// before it can be taken. Conversion to the calendar runs the era division of the
// day count (reciprocal multiply, then remainder), then the year and month
// divisions in later stages.
// Throughput is one item per cycle while the receiver keeps taking results.
// Reset empties the pipeline and the output; i_in.ready is low during reset and
// is registered, so it rises after reset is released. When the receiver stalls, the result holds
// on o_out, one more item is caught in a skid register, then i_in.ready drops
// and the pipeline freezes in place until the output is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_day_number_converter
    import cdnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdnc_chan_if.sink   i_in,
    cdnc_chan_if.source o_out
);

    localparam int STAGES = 9;

    // Control
    logic              r_adv;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_op;
    logic              r_out_vld;
    logic              r_skid_vld;
    logic              n_out_vld;
    logic              n_skid_vld;
    logic              w_push;
    logic              w_out_free;
    t_out_item         r_out;
    t_out_item         r_skid;
    t_out_item         w_pipe_item;

    // Stage 1
    logic [13:0] r_s1_yr,    n_s1_yr;
    logic [3:0]  r_s1_mo,    n_s1_mo;
    logic [4:0]  r_s1_day;
    logic        r_s1_low,   n_s1_low;
    logic [16:0] r_s1_secs,  n_s1_secs;
    logic [22:0] r_s1_dcount, n_s1_dcount;
    logic [16:0] r_s1_sod,   n_s1_sod;
    // Stage 2
    logic [28:0] r_s2_cprod, n_s2_cprod;
    logic [13:0] r_s2_yr;
    logic [3:0]  r_s2_mo;
    logic [4:0]  r_s2_day;
    logic        r_s2_low;
    logic [16:0] r_s2_secs;
    logic [21:0] r_s2_jm1,   n_s2_jm1;
    logic [16:0] r_s2_sod,   n_s2_sod;
    // Stage 3
    logic [7:0]  r_s3_cent,  n_s3_cent;
    logic [6:0]  r_s3_yrem,  n_s3_yrem;
    logic [3:0]  r_s3_mo;
    logic [4:0]  r_s3_day;
    logic        r_s3_low;
    logic [16:0] r_s3_secs;
    logic [47:0] r_s3_xprod, n_s3_xprod;
    logic [23:0] r_s3_x,     n_s3_x;
    logic [33:0] r_s3_mprod, n_s3_mprod;
    logic [16:0] r_s3_sod;
    // Stage 4
    logic [22:0] r_s4_a,     n_s4_a;
    logic [15:0] r_s4_b,     n_s4_b;
    logic [8:0]  r_s4_c,     n_s4_c;
    logic [4:0]  r_s4_day;
    logic        r_s4_low;
    logic [16:0] r_s4_secs;
    logic [6:0]  r_s4_rcent, n_s4_rcent;
    logic [17:0] r_s4_j2,    n_s4_j2;
    logic [10:0] r_s4_mt,    n_s4_mt;
    logic [5:0]  r_s4_sec,   n_s4_sec;
    // Stage 5
    logic [22:0] r_s5_sum,   n_s5_sum;
    logic        r_s5_scarry, n_s5_scarry;
    logic [16:0] r_s5_secs,  n_s5_secs;
    logic        r_s5_low;
    logic [6:0]  r_s5_rcent;
    logic [34:0] r_s5_yprod, n_s5_yprod;
    logic [17:0] r_s5_x2,    n_s5_x2;
    logic [21:0] r_s5_hprod, n_s5_hprod;
    logic [10:0] r_s5_mt;
    logic [5:0]  r_s5_sec;
    // Stage 6
    logic [23:0] r_s6_days,  n_s6_days;
    logic [16:0] r_s6_secs;
    logic        r_s6_low;
    logic [6:0]  r_s6_rcent;
    logic [6:0]  r_s6_y,     n_s6_y;
    logic [10:0] w_s6_rem;
    logic [8:0]  r_s6_d2,    n_s6_d2;
    logic [4:0]  r_s6_hour,  n_s6_hour;
    logic [5:0]  r_s6_min,   n_s6_min;
    logic [5:0]  r_s6_sec;
    // Stage 7
    logic [21:0] r_s7_fday,  n_s7_fday;
    logic [16:0] r_s7_fsod,  n_s7_fsod;
    logic [6:0]  r_s7_rcent;
    logic [6:0]  r_s7_y;
    logic [22:0] r_s7_mprod, n_s7_mprod;
    logic [10:0] r_s7_x3,    n_s7_x3;
    logic [4:0]  r_s7_hour;
    logic [5:0]  r_s7_min;
    logic [5:0]  r_s7_sec;
    // Stage 8
    logic [21:0] r_s8_fday;
    logic [16:0] r_s8_fsod;
    logic [6:0]  r_s8_rcent;
    logic [6:0]  r_s8_y;
    logic [3:0]  r_s8_mo,    n_s8_mo;
    logic [7:0]  r_s8_rem,   n_s8_rem;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_min;
    logic [5:0]  r_s8_sec;
    // Stage 9
    logic [21:0] r_s9_fday;
    logic [16:0] r_s9_fsod;
    logic [13:0] r_s9_year,  n_s9_year;
    logic [3:0]  r_s9_mon,   n_s9_mon;
    logic [15:0] w_s9_dprod;
    logic [4:0]  r_s9_mday,  n_s9_mday;
    logic [4:0]  r_s9_hour;
    logic [5:0]  r_s9_min;
    logic [5:0]  r_s9_sec;

    logic w_s1_mar;
    logic w_s1_wrap;
    logic w_s2_over;
    logic w_s7_zero;
    logic w_s7_over;

    assign i_in.ready = r_adv;

    // Stage 1: shift the year to start in March, sum the clock time, fold the
    // excess seconds of the day count side into whole days.
    always_comb begin
        w_s1_mar    = i_in.data.cal_month > 4'd1;
        n_s1_low    = i_in.data.cal_year < 14'(YEAR_MIN);
        n_s1_yr     = w_s1_mar ? i_in.data.cal_year : i_in.data.cal_year - 14'd1;
        n_s1_mo     = w_s1_mar ? i_in.data.cal_month - 4'd2 : i_in.data.cal_month + 4'd10;
        n_s1_secs   = 17'(i_in.data.clock_hour) * 17'd3600
                    + 17'(i_in.data.clock_minute) * 17'd60
                    + 17'(i_in.data.clock_second);
        w_s1_wrap   = i_in.data.second_of_day >= 17'(SEC_PER_DAY);
        n_s1_sod    = w_s1_wrap ? i_in.data.second_of_day - 17'(SEC_PER_DAY)
                                : i_in.data.second_of_day;
        n_s1_dcount = 23'(i_in.data.day_index) + 23'(w_s1_wrap);
    end

    // Stage 2: century product; clamp the day count and form 4 * j - 1 minus its low bits.
    always_comb begin
        n_s2_cprod = 29'(r_s1_yr) * 29'(RCP_DIV100);
        w_s2_over  = r_s1_dcount > 23'(MAX_DAY);
        n_s2_jm1   = w_s2_over ? 22'(MAX_DAY + EPOCH_SHIFT - 1)
                               : r_s1_dcount[21:0] + 22'(EPOCH_SHIFT - 1);
        n_s2_sod   = w_s2_over ? 17'(SEC_PER_DAY - 1) : r_s1_sod;
    end

    // Stage 3: century and year of century; era product; minute product.
    always_comb begin
        n_s3_cent  = r_s2_cprod[K_DIV100 +: 8];
        n_s3_yrem  = 7'(r_s2_yr - 14'(n_s3_cent) * 14'd100);
        n_s3_x     = {r_s2_jm1, 2'b11};
        n_s3_xprod = 48'(n_s3_x) * 48'(RCP_DIV_ERA);
        n_s3_mprod = 34'(r_s2_sod) * 34'(RCP_DIV60);
    end

    // Stage 4: the three day terms; era quotient and remainder; minutes and seconds.
    always_comb begin
        n_s4_a     = 23'((25'(r_s3_cent) * 25'(DAYS_PER_ERA)) >> 2);
        n_s4_b     = 16'((18'(r_s3_yrem) * 18'(DAYS_PER_QUAD)) >> 2);
        n_s4_c     = days_before_month(r_s3_mo);
        n_s4_rcent = r_s3_xprod[K_DIV_ERA +: 7];
        n_s4_j2    = 18'(r_s3_x - 24'(n_s4_rcent) * 24'(DAYS_PER_ERA));
        n_s4_mt    = r_s3_mprod[K_DIV60 +: 11];
        n_s4_sec   = 6'(r_s3_sod - 17'(n_s4_mt) * 17'd60);
    end

    // Stage 5: day sum and second carry; year-of-era product; hour product.
    always_comb begin
        n_s5_sum    = 23'(r_s4_a) + 23'(r_s4_b) + 23'(r_s4_c) + 23'(r_s4_day);
        n_s5_scarry = r_s4_secs >= 17'(SEC_PER_DAY);
        n_s5_secs   = n_s5_scarry ? r_s4_secs - 17'(SEC_PER_DAY) : r_s4_secs;
        n_s5_x2     = {r_s4_j2[17:2], 2'b11};
        n_s5_yprod  = 35'(n_s5_x2) * 35'(RCP_DIV_QUAD);
        n_s5_hprod  = 22'(r_s4_mt) * 22'(RCP_DIV60H);
    end

    // Stage 6: signed day count; year of era and day of year; hour and minute.
    always_comb begin
        n_s6_days = 24'(r_s5_sum) + 24'(r_s5_scarry) - 24'(EPOCH_SHIFT);
        n_s6_y    = r_s5_yprod[K_DIV_QUAD +: 7];
        w_s6_rem  = 11'(r_s5_x2 - 18'(n_s6_y) * 18'(DAYS_PER_QUAD));
        n_s6_d2   = 9'(w_s6_rem[10:2]) + 9'd1;
        n_s6_hour = r_s5_hprod[K_DIV60H +: 5];
        n_s6_min  = 6'(r_s5_mt - 11'(n_s6_hour) * 11'd60);
    end

    // Stage 7: saturate the day count result; month product.
    always_comb begin
        w_s7_zero  = r_s6_low || r_s6_days[23];
        w_s7_over  = !r_s6_days[23] && (r_s6_days[22:0] > 23'(MAX_DAY));
        if (w_s7_zero) begin
            n_s7_fday = '0;
            n_s7_fsod = '0;
        end else if (w_s7_over) begin
            n_s7_fday = 22'(MAX_DAY);
            n_s7_fsod = 17'(SEC_PER_DAY - 1);
        end else begin
            n_s7_fday = r_s6_days[21:0];
            n_s7_fsod = r_s6_secs;
        end
        n_s7_x3    = 11'(r_s6_d2) * 11'd5 - 11'd3;
        n_s7_mprod = 23'(n_s7_x3) * 23'(RCP_DIV_MON);
    end

    // Stage 8: March-based month and its remainder.
    always_comb begin
        n_s8_mo  = r_s7_mprod[K_DIV_MON +: 4];
        n_s8_rem = 8'(r_s7_x3 - 11'(n_s8_mo) * 11'(MONTH_SPAN));
    end

    // Stage 9: day of month, calendar year and January-based month.
    always_comb begin
        w_s9_dprod = 16'(r_s8_rem) * 16'(RCP_DIV5);
        n_s9_mday  = w_s9_dprod[K_DIV5 +: 5] + 5'd1;
        n_s9_year  = 14'(r_s8_rcent) * 14'd100 + 14'(r_s8_y) + 14'(r_s8_mo >= 4'd10);
        n_s9_mon   = (r_s8_mo < 4'd10) ? r_s8_mo + 4'd2 : r_s8_mo - 4'd10;
    end

    always_ff @(posedge i_clk) begin
        if (r_adv) begin
            r_op        <= {r_op[STAGES-2:0], i_in.data.opcode};

            r_s1_yr     <= n_s1_yr;
            r_s1_mo     <= n_s1_mo;
            r_s1_day    <= i_in.data.cal_day;
            r_s1_low    <= n_s1_low;
            r_s1_secs   <= n_s1_secs;
            r_s1_dcount <= n_s1_dcount;
            r_s1_sod    <= n_s1_sod;

            r_s2_cprod  <= n_s2_cprod;
            r_s2_yr     <= r_s1_yr;
            r_s2_mo     <= r_s1_mo;
            r_s2_day    <= r_s1_day;
            r_s2_low    <= r_s1_low;
            r_s2_secs   <= r_s1_secs;
            r_s2_jm1    <= n_s2_jm1;
            r_s2_sod    <= n_s2_sod;

            r_s3_cent   <= n_s3_cent;
            r_s3_yrem   <= n_s3_yrem;
            r_s3_mo     <= r_s2_mo;
            r_s3_day    <= r_s2_day;
            r_s3_low    <= r_s2_low;
            r_s3_secs   <= r_s2_secs;
            r_s3_xprod  <= n_s3_xprod;
            r_s3_x      <= n_s3_x;
            r_s3_mprod  <= n_s3_mprod;
            r_s3_sod    <= r_s2_sod;

            r_s4_a      <= n_s4_a;
            r_s4_b      <= n_s4_b;
            r_s4_c      <= n_s4_c;
            r_s4_day    <= r_s3_day;
            r_s4_low    <= r_s3_low;
            r_s4_secs   <= r_s3_secs;
            r_s4_rcent  <= n_s4_rcent;
            r_s4_j2     <= n_s4_j2;
            r_s4_mt     <= n_s4_mt;
            r_s4_sec    <= n_s4_sec;

            r_s5_sum    <= n_s5_sum;
            r_s5_scarry <= n_s5_scarry;
            r_s5_secs   <= n_s5_secs;
            r_s5_low    <= r_s4_low;
            r_s5_rcent  <= r_s4_rcent;
            r_s5_yprod  <= n_s5_yprod;
            r_s5_x2     <= n_s5_x2;
            r_s5_hprod  <= n_s5_hprod;
            r_s5_mt     <= r_s4_mt;
            r_s5_sec    <= r_s4_sec;

            r_s6_days   <= n_s6_days;
            r_s6_secs   <= r_s5_secs;
            r_s6_low    <= r_s5_low;
            r_s6_rcent  <= r_s5_rcent;
            r_s6_y      <= n_s6_y;
            r_s6_d2     <= n_s6_d2;
            r_s6_hour   <= n_s6_hour;
            r_s6_min    <= n_s6_min;
            r_s6_sec    <= r_s5_sec;

            r_s7_fday   <= n_s7_fday;
            r_s7_fsod   <= n_s7_fsod;
            r_s7_rcent  <= r_s6_rcent;
            r_s7_y      <= r_s6_y;
            r_s7_mprod  <= n_s7_mprod;
            r_s7_x3     <= n_s7_x3;
            r_s7_hour   <= r_s6_hour;
            r_s7_min    <= r_s6_min;
            r_s7_sec    <= r_s6_sec;

            r_s8_fday   <= r_s7_fday;
            r_s8_fsod   <= r_s7_fsod;
            r_s8_rcent  <= r_s7_rcent;
            r_s8_y      <= r_s7_y;
            r_s8_mo     <= n_s8_mo;
            r_s8_rem    <= n_s8_rem;
            r_s8_hour   <= r_s7_hour;
            r_s8_min    <= r_s7_min;
            r_s8_sec    <= r_s7_sec;

            r_s9_fday   <= r_s8_fday;
            r_s9_fsod   <= r_s8_fsod;
            r_s9_year   <= n_s9_year;
            r_s9_mon    <= n_s9_mon;
            r_s9_mday   <= n_s9_mday;
            r_s9_hour   <= r_s8_hour;
            r_s9_min    <= r_s8_min;
            r_s9_sec    <= r_s8_sec;
        end
    end

    // The fields of the direction not requested stay zero.
    always_comb begin
        w_pipe_item = '0;
        if (r_op[STAGES-1] == OP_TO_CAL) begin
            w_pipe_item.res_year   = r_s9_year;
            w_pipe_item.res_month  = r_s9_mon;
            w_pipe_item.res_day    = r_s9_mday;
            w_pipe_item.res_hour   = r_s9_hour;
            w_pipe_item.res_minute = r_s9_min;
            w_pipe_item.res_second = r_s9_sec;
        end else begin
            w_pipe_item.res_day_index     = r_s9_fday;
            w_pipe_item.res_second_of_day = r_s9_fsod;
        end
    end

    // Output register with one skid entry; the pipeline advances only while
    // the skid entry is empty, so a stalled receiver never drops an item.
    always_comb begin
        w_push     = r_adv && r_vld[STAGES-1];
        w_out_free = !r_out_vld || o_out.ready;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (w_out_free) begin
            if (r_skid_vld) begin
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = w_push;
            end
        end else if (w_push) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_pipe_item;
            end
        end else if (w_push) begin
            r_skid <= w_pipe_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv      <= 1'b0;
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_adv      <= !n_skid_vld;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
            if (r_adv) begin
                r_vld <= {r_vld[STAGES-2:0], i_in.valid};
            end
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    `ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid entry held while output register is empty")
    `ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, w_push && r_out_vld && !o_out.ready, r_skid_vld && r_out_vld, "item leaving the pipeline during a stall was not caught")
    `ASSERT_SAME(a_day_count_range, i_clk, i_rst_n, r_out_vld, (r_out.res_day_index <= 22'(MAX_DAY)) && (r_out.res_second_of_day < 17'(SEC_PER_DAY)), "day count result out of range")
    `ASSERT_SAME(a_calendar_range, i_clk, i_rst_n, r_out_vld, (r_out.res_month < 4'd12) && (r_out.res_hour < 5'd24) && (r_out.res_minute < 6'd60) && (r_out.res_second < 6'd60), "calendar result out of range")

endmodule
